>>> src/adcavg_pkg.sv
// ----------------------------------------------------------------------------
// adcavg_pkg
// Shared types and constants for the averaging ADC millivolt converter.
// ----------------------------------------------------------------------------
package adcavg_pkg;

   // Sample and field widths
   localparam int SAMPLE_W      = 12;
   localparam int CAL_W         = 12;
   localparam int AVG_W         = 11;
   localparam int CNT_W         = 10;
   localparam int SUM_W         = 22;
   localparam int MV_W          = 16;
   localparam int CSR_DATA_W    = 12;

   // Ratiometric scale: 3300 * cal fits in 24 bits, scale itself in 12
   localparam int SCALE_W       = 12;
   localparam int SCALE_PROD_W  = 24;

   // Shared divider: widest dividend is scale * channel average
   localparam int DVD_W         = SCALE_W + SUM_W;
   localparam int DVS_W         = SUM_W;
   localparam int STEP_W        = 6;

   // Left-alignment padding for narrower dividends
   localparam int SUM_PAD       = DVD_W - SUM_W;

   localparam logic [STEP_W-1:0] SUM_STEPS   = STEP_W'(SUM_W);
   localparam logic [STEP_W-1:0] MV_STEPS    = STEP_W'(DVD_W);

   // Arithmetic constants
   localparam logic [SCALE_W-1:0]  SUPPLY_MV   = SCALE_W'(3300);
   localparam logic [AVG_W-1:0]    MAX_AVERAGE = AVG_W'(1024);
   localparam logic [MV_W-1:0]     MV_LIMIT    = '1;

   // Register reset values
   localparam logic [CAL_W-1:0]    CAL_RESET   = CAL_W'(1500);
   localparam logic [AVG_W-1:0]    AVG_RESET   = AVG_W'(16);

   // Register indexes
   localparam logic REG_VREF_CAL  = 1'b0;
   localparam logic REG_AVG_COUNT = 1'b1;

   // Divider command
   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_CH,
      ST_DIV_REF,
      ST_MUL,
      ST_MV_START,
      ST_DIV_MV,
      ST_FINISH
   } state_type;

endpackage

>>> src/adcavg_div.sv
// ----------------------------------------------------------------------------
// adcavg_div
// Restoring divider, one quotient bit per cycle. The dividend is
// left-aligned; once done pulses, the quotient sits in quotient.
// ----------------------------------------------------------------------------
module adcavg_div
   import adcavg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_cmd_type       cmd,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DVS_W-1:0]  divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   logic [DVS_W:0]    rem_ff,  rem_in;
   logic [DVD_W-1:0]  quo_ff,  quo_in;
   logic [DVS_W-1:0]  dvs_ff,  dvs_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              qbit;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      qbit  = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (cmd.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? diff : trial;
         quo_in = {quo_ff[DVD_W-2:0], qbit};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> src/adc_average_vref_millivolts.sv
// ----------------------------------------------------------------------------
// adc_average_vref_millivolts
// Averages channel and internal-reference scans and converts the channel
// average to millivolts against the calibrated reference.
// ----------------------------------------------------------------------------
// Each scan that does not complete a block is absorbed and the next
// scan can follow at once. The scan that completes a block starts a
// result sequence, during which req_stall is high; the result appears on
// rsp_valid as it ends, and the next scan can be taken in that same cycle.
// The sequence is spent in the shared bit-serial divider, which runs three
// divisions in turn (channel sum by count, 22 steps; reference sum by
// count, 22 steps; scaled channel average by reference average, 34
// steps), plus a multiply state, a divider start state and an output
// state, which waits while an earlier result is held by rsp_stall. When
// the reference average is zero the last division and its start state
// are skipped. The scale 3300 * calibration / 4095 is formed by a shift
// and add, off the divider. The result is held in an output register, so
// new scans are taken while it waits on rsp_stall. Write the CSRs (index 0:
// vref calibration, index 1: average count) only while idle.
// ----------------------------------------------------------------------------
module adc_average_vref_millivolts
   import adcavg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_channel_sample,
   input  logic [SAMPLE_W-1:0]   req_reference_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MV_W-1:0]       rsp_millivolts,
   output logic                  rsp_saturated,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   state_type               state_ff, state_in;
   logic [CAL_W-1:0]        cal_ff;
   logic [AVG_W-1:0]        avg_ff;
   logic [SUM_W-1:0]        ch_sum_ff, ch_sum_in;
   logic [SUM_W-1:0]        ref_sum_ff, ref_sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]        ch_avg_ff, ch_avg_in;
   logic [SUM_W-1:0]        ref_avg_ff, ref_avg_in;
   logic [SCALE_W-1:0]      scale_ff;
   logic [SCALE_PROD_W-1:0] scale_prod_ff;
   logic [DVD_W-1:0]        mv_prod_ff, mv_prod_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]         rsp_mv_ff, rsp_mv_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   logic [AVG_W-1:0]        eff_count;
   logic [AVG_W-1:0]        cnt_inc;
   logic [SCALE_PROD_W:0]   scale_sum;
   logic                    req_xfer;
   logic                    out_free;
   logic                    quo_over;
   div_cmd_type             div_cmd;
   logic [DVD_W-1:0]        div_dividend;
   logic [DVS_W-1:0]        div_divisor;
   logic                    div_done;
   logic [DVD_W-1:0]        div_quotient;

   adcavg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Average count clamped to 1..MAX_AVERAGE
   always_comb begin
      if (avg_ff == '0) begin
         eff_count = AVG_W'(1);
      end else if (avg_ff > MAX_AVERAGE) begin
         eff_count = MAX_AVERAGE;
      end else begin
         eff_count = avg_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign cnt_inc   = {1'b0, cnt_ff} + AVG_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign quo_over  = |div_quotient[DVD_W-1:MV_W];

   // Divide by 4095 as (x + (x >> 12) + 1) >> 12, exact for x below 4095 * 4096
   assign scale_sum = {1'b0, scale_prod_ff}
                      + {{(SAMPLE_W+1){1'b0}}, scale_prod_ff[SCALE_PROD_W-1:SAMPLE_W]}
                      + (SCALE_PROD_W+1)'(1);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      ch_sum_in    = ch_sum_ff;
      ref_sum_in   = ref_sum_ff;
      cnt_in       = cnt_ff;
      ch_avg_in    = ch_avg_ff;
      ref_avg_in   = ref_avg_ff;
      mv_prod_in   = mv_prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_mv_in    = rsp_mv_ff;
      rsp_sat_in   = rsp_sat_ff;
      div_cmd      = '{start: 1'b0, steps: SUM_STEPS};
      div_dividend = {ch_sum_ff, {SUM_PAD{1'b0}}};
      div_divisor  = {{(DVS_W-AVG_W){1'b0}}, eff_count};

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ch_sum_in  = ch_sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, req_channel_sample};
               ref_sum_in = ref_sum_ff + {{(SUM_W-SAMPLE_W){1'b0}}, req_reference_sample};
               cnt_in     = cnt_inc[CNT_W-1:0];
               if (cnt_inc >= eff_count) begin
                  // channel sum including this scan
                  div_dividend = {ch_sum_in, {SUM_PAD{1'b0}}};
                  div_cmd      = '{start: 1'b1, steps: SUM_STEPS};
                  state_in     = ST_DIV_CH;
               end
            end
         end
         ST_DIV_CH: begin
            div_dividend = {ref_sum_ff, {SUM_PAD{1'b0}}};
            if (div_done) begin
               ch_avg_in = div_quotient[SUM_W-1:0];
               div_cmd   = '{start: 1'b1, steps: SUM_STEPS};
               state_in  = ST_DIV_REF;
            end
         end
         ST_DIV_REF: begin
            if (div_done) begin
               ref_avg_in = div_quotient[SUM_W-1:0];
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            mv_prod_in = {{SUM_W{1'b0}}, scale_ff} * {{SCALE_W{1'b0}}, ch_avg_ff};
            // No division when the reference average is zero
            state_in   = (ref_avg_ff == '0) ? ST_FINISH : ST_MV_START;
         end
         ST_MV_START: begin
            div_dividend = mv_prod_ff;
            div_divisor  = ref_avg_ff;
            div_cmd      = '{start: 1'b1, steps: MV_STEPS};
            state_in     = ST_DIV_MV;
         end
         ST_DIV_MV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Saturate on zero reference or oversized quotient
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = (ref_avg_ff == '0) || quo_over;
               rsp_mv_in    = rsp_sat_in ? MV_LIMIT : div_quotient[MV_W-1:0];
               ch_sum_in    = '0;
               ref_sum_in   = '0;
               cnt_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and accumulator registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_sum_ff    <= '0;
         ref_sum_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_sum_ff    <= ch_sum_in;
         ref_sum_ff   <= ref_sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= CAL_RESET;
         avg_ff <= AVG_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_VREF_CAL:  cal_ff <= csr_data[CAL_W-1:0];
            REG_AVG_COUNT: avg_ff <= csr_data[AVG_W-1:0];
            default:       cal_ff <= cal_ff;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ch_avg_ff     <= ch_avg_in;
      ref_avg_ff    <= ref_avg_in;
      scale_ff      <= scale_sum[SAMPLE_W+SCALE_W-1:SAMPLE_W];
      mv_prod_ff    <= mv_prod_in;
      scale_prod_ff <= {{(SCALE_PROD_W-SCALE_W){1'b0}}, SUPPLY_MV}
                       * {{(SCALE_PROD_W-CAL_W){1'b0}}, cal_ff};
      rsp_mv_ff     <= rsp_mv_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_millivolts = rsp_mv_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule
